// ----- hdl/pfv_pkg.sv -----
// ----------------------------------------------------------------------------
// pfv_pkg - shared widths and register codes
// Widths of the pipelined square-root and divide cores and the codes of the
// configuration registers of the potential field velocity block.
// ----------------------------------------------------------------------------
package pfv_pkg;

	// square-root core: 64-bit radicand, 32-bit root, one root bit a stage
	localparam int RAD_W  = 64;
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W  = ROOT_W + 2;

	// divide core: 64-bit dividend, 32-bit divisor, one quotient bit a stage
	localparam int NUM_W = 64;
	localparam int DEN_W = 32;
	localparam int Q_W   = 33;

	// configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REPULSE_GAIN     = 3'd0,
		REG_ATTRACT_GAIN     = 3'd1,
		REG_REPULSE_MAX_DIST = 3'd2,
		REG_PARABOLIC_BOUND  = 3'd3,
		REG_SUCCESS_RADIUS   = 3'd4,
		REG_ROBOT_SPEED      = 3'd5
	} cfg_reg_t;

endpackage

// ----- hdl/pfv_isqrt.sv -----
// ----------------------------------------------------------------------------
// pfv_isqrt - pipelined integer square root
// floor(sqrt(rad)), one root bit resolved in each register stage; a new
// radicand may enter on every enabled clock.
// ----------------------------------------------------------------------------
module pfv_isqrt
	import pfv_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [RAD_W-1:0]  rad,
	output logic [ROOT_W-1:0] root
);

	logic [RAD_W-1:0]  rad_q  [ROOT_W];
	logic [REM_W-1:0]  rem_q  [ROOT_W];
	logic [ROOT_W-1:0] root_q [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stg
		logic [RAD_W-1:0]  rad_p;
		logic [REM_W-1:0]  rem_p;
		logic [ROOT_W-1:0] root_p;
		logic [REM_W+1:0]  part;
		logic [REM_W+1:0]  trial;
		logic [REM_W+1:0]  diff;

		if (k == 0) begin : g_first
			assign rad_p  = rad;
			assign rem_p  = '0;
			assign root_p = '0;
		end else begin : g_next
			assign rad_p  = rad_q[k-1];
			assign rem_p  = rem_q[k-1];
			assign root_p = root_q[k-1];
		end

		// bring down the next two radicand bits and try root*4+1
		assign part  = {rem_p, rad_p[RAD_W-1 -: 2]};
		assign trial = {2'b00, root_p, 2'b01};
		assign diff  = part - trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rad_q[k] <= rad_p << 2;
				if (part >= trial) begin
					rem_q[k]  <= diff[REM_W-1:0];
					root_q[k] <= {root_p[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q[k]  <= part[REM_W-1:0];
					root_q[k] <= {root_p[ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign root = root_q[ROOT_W-1];

endmodule

// ----- hdl/pfv_div.sv -----
// ----------------------------------------------------------------------------
// pfv_div - pipelined restoring divider
// floor(num/den) for quotients below 2^Q_W, one quotient bit per register
// stage; one division may enter on every enabled clock.
// ----------------------------------------------------------------------------
module pfv_div
	import pfv_pkg::*;
(
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [Q_W-1:0]   quo
);

	logic [NUM_W-1:0] num_q [Q_W];
	logic [DEN_W-1:0] den_q [Q_W];
	logic [DEN_W-1:0] rem_q [Q_W];
	logic [Q_W-1:0]   quo_q [Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_stg
		logic [NUM_W-1:0] num_p;
		logic [DEN_W-1:0] den_p;
		logic [DEN_W-1:0] rem_p;
		logic [Q_W-1:0]   quo_p;
		logic [DEN_W:0]   part;
		logic [DEN_W:0]   diff;

		if (k == 0) begin : g_first
			assign num_p = num;
			assign den_p = den;
			assign rem_p = {{(DEN_W-(NUM_W-Q_W)){1'b0}}, num[NUM_W-1:Q_W]};
			assign quo_p = '0;
		end else begin : g_next
			assign num_p = num_q[k-1];
			assign den_p = den_q[k-1];
			assign rem_p = rem_q[k-1];
			assign quo_p = quo_q[k-1];
		end

		// shift in the next dividend bit and subtract if it fits
		assign part = {rem_p, num_p[Q_W-1-k]};
		assign diff = part - {1'b0, den_p};

		always_ff @(posedge clk) begin
			if (en) begin
				num_q[k] <= num_p;
				den_q[k] <= den_p;
				if (part >= {1'b0, den_p}) begin
					rem_q[k] <= diff[DEN_W-1:0];
					quo_q[k] <= {quo_p[Q_W-2:0], 1'b1};
				end else begin
					rem_q[k] <= part[DEN_W-1:0];
					quo_q[k] <= {quo_p[Q_W-2:0], 1'b0};
				end
			end
		end
	end

	assign quo = quo_q[Q_W-1];

endmodule

// ----- hdl/potential_field_velocity.sv -----
// ----------------------------------------------------------------------------
// potential_field_velocity - potential field velocity command
// Attraction toward the goal (zero, parabolic or conic) plus 1/d^2 repulsion
// from the nearest obstacle, normalized and scaled to the robot speed.
// Signed Q16.16 throughout.
//
//   channel  dir  handshake             payload
//   s_*      in   s_tvalid / s_tready   tdata: pose; tuser: obstacle_valid
//   m_*      out  m_tvalid / m_tready   tdata: velocity_x/y/z
//   cfg_*    in   cfg_we                cfg_index, cfg_wdata
//
// One pose per clock while the output is not held; the delay is set by the
// two chained root/divide passes (norms then unit vectors, gradient norm then
// speed scaling), each core resolving one bit per stage.
// Reset clears the valid bits and loads the register defaults.
// When a result waits on m_tready the whole pipeline holds; nothing is lost.
// ----------------------------------------------------------------------------
module potential_field_velocity
	import pfv_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// robot_x, robot_y, robot_z, goal_x, goal_y, goal_z,
	// obstacle_x, obstacle_y, obstacle_z (32 bits each, lowest first)
	input  logic [287:0]         s_tdata,
	// obstacle_valid
	input  logic                 s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// velocity_x, velocity_y, velocity_z (32 bits each, lowest first)
	output logic [95:0]          m_tdata,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_wdata
);

	localparam int MAG_W = 47;
	localparam int GRD_W = MAG_W + 2;
	localparam int H_W   = 31;
	localparam int HV_W  = 2 * H_W;
	localparam int SH_W  = 5;
	localparam int LO_W  = 24;
	localparam int PP_W  = LO_W + Q_W;
	localparam int N_STG = 16 + 2 * ROOT_W + 2 * Q_W;
	localparam logic [MAG_W-1:0] GMAX = '1;

	typedef struct packed {
		logic        neg;
		logic        pos;
		logic [31:0] mag;
	} dif_t;

	typedef struct packed {
		logic [2:0][31:0] dg;
		logic [2:0]       dg_neg;
		logic [2:0][31:0] ob;
		logic [2:0]       ob_pos;
		logic             ov;
	} pos_t;

	typedef struct packed {
		logic [ROOT_W-1:0] n;
		logic [ROOT_W-1:0] m;
	} nm_t;

	typedef struct packed {
		logic [2:0][HV_W-1:0] hv;
		logic [2:0]           neg;
		logic                 zero;
	} fin_t;

	typedef struct packed {
		logic [2:0] neg;
		logic       zero;
	} sg_t;

	// saturated difference b - a as sign flags and magnitude
	function automatic dif_t diff_abs(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] d;
		logic [32:0] m;
		dif_t        r;
		d = {b[31], b} - {a[31], a};
		m = d[32] ? (33'd0 - d) : d;
		r.neg = d[32];
		r.pos = !d[32] && (d != 33'd0);
		if (d[32]) begin
			r.mag = (m > 33'h0_8000_0000) ? 32'h8000_0000 : m[31:0];
		end else begin
			r.mag = (m > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
		end
		return r;
	endfunction

	function automatic logic [MAG_W-1:0] sat_mag(input logic [MAG_W:0] v);
		return (v > {1'b0, GMAX}) ? GMAX : v[MAG_W-1:0];
	endfunction

	// Q16.16 product clamped to GMAX
	function automatic logic [MAG_W-1:0] qmul(input logic [MAG_W:0] a,
		input logic [Q_W-1:0] b);
		logic [MAG_W+Q_W:0] p;
		p = (MAG_W+Q_W+1)'(a) * (MAG_W+Q_W+1)'(b);
		if (p[MAG_W+Q_W:16] > (MAG_W+Q_W-15)'(GMAX)) begin
			return GMAX;
		end
		return p[MAG_W+15:16];
	endfunction

	// join high and low partial products into a Q16.16 product clamped to GMAX
	function automatic logic [MAG_W-1:0] qjoin(input logic [PP_W-1:0] ph,
		input logic [PP_W-1:0] pl);
		logic [MAG_W+Q_W:0] p;
		p = {ph, {LO_W{1'b0}}} + (MAG_W+Q_W+1)'(pl);
		if (p[MAG_W+Q_W:16] > (MAG_W+Q_W-15)'(GMAX)) begin
			return GMAX;
		end
		return p[MAG_W+15:16];
	endfunction

	function automatic logic [5:0] msb_pos(input logic [GRD_W-1:0] v);
		logic [5:0] p;
		p = '0;
		for (int k = 0; k < GRD_W; k++) begin
			if (v[k]) begin
				p = 6'(k);
			end
		end
		return p;
	endfunction

	logic              en;
	logic [N_STG:1]    vld_q;
	logic [31:0]       rg_q;
	logic [31:0]       ag_q;
	logic [30:0]       md_q;
	logic [30:0]       pb_q;
	logic [30:0]       sr_q;
	logic [30:0]       sp_q;
	logic [MAG_W-1:0]  p_q;
	logic [62:0]       pprod;

	// handshake: the pipeline moves unless the output is held
	assign en       = !vld_q[N_STG] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[N_STG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[N_STG-1:1], s_tvalid};
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rg_q <= 32'd65536;
			ag_q <= 32'd65536;
			md_q <= 31'd131072;
			pb_q <= 31'd65536;
			sr_q <= 31'd16384;
			sp_q <= 31'd32768;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_REPULSE_GAIN:     rg_q <= cfg_wdata;
				REG_ATTRACT_GAIN:     ag_q <= cfg_wdata;
				REG_REPULSE_MAX_DIST: md_q <= cfg_wdata[30:0];
				REG_PARABOLIC_BOUND:  pb_q <= cfg_wdata[30:0];
				REG_SUCCESS_RADIUS:   sr_q <= cfg_wdata[30:0];
				REG_ROBOT_SPEED:      sp_q <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	// conic gain follows the registers
	assign pprod = 63'(pb_q) * 63'(ag_q);
	always_ff @(posedge clk) begin
		p_q <= pprod[62:16];
	end

	// ---------------- s1: difference vectors ----------------
	dif_t dgd_w [3];
	dif_t obd_w [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dgd_w[i] = diff_abs(s_tdata[32*i +: 32], s_tdata[96+32*i +: 32]);
			obd_w[i] = diff_abs(s_tdata[32*i +: 32], s_tdata[192+32*i +: 32]);
		end
	end

	pos_t pos_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pos_s1.dg[i]     <= dgd_w[i].mag;
				pos_s1.dg_neg[i] <= dgd_w[i].neg;
				pos_s1.ob[i]     <= obd_w[i].mag;
				pos_s1.ob_pos[i] <= obd_w[i].pos;
			end
			pos_s1.ov <= s_tuser;
		end
	end

	// ---------------- s2: squares ----------------
	pos_t             pos_s2;
	logic [2:0][63:0] sqg_s2;
	logic [2:0][63:0] sqo_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			pos_s2 <= pos_s1;
			for (int i = 0; i < 3; i++) begin
				sqg_s2[i] <= 64'(pos_s1.dg[i]) * 64'(pos_s1.dg[i]);
				sqo_s2[i] <= 64'(pos_s1.ob[i]) * 64'(pos_s1.ob[i]);
			end
		end
	end

	// ---------------- s3: sums of squares ----------------
	pos_t        pos_s3;
	logic [63:0] sumg_s3;
	logic [63:0] sumo_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			pos_s3  <= pos_s2;
			sumg_s3 <= sqg_s2[0] + sqg_s2[1] + sqg_s2[2];
			sumo_s3 <= sqo_s2[0] + sqo_s2[1] + sqo_s2[2];
		end
	end

	// norms of the goal and obstacle vectors
	logic [ROOT_W-1:0] n_w;
	logic [ROOT_W-1:0] m_w;
	pfv_isqrt u_sqn (.clk(clk), .en(en), .rad(sumg_s3), .root(n_w));
	pfv_isqrt u_sqm (.clk(clk), .en(en), .rad(sumo_s3), .root(m_w));

	// carry the vectors past both cores
	pos_t pos_dl_q [ROOT_W+Q_W];
	nm_t  nm_dl_q  [Q_W];
	always_ff @(posedge clk) begin
		if (en) begin
			pos_dl_q[0] <= pos_s3;
			for (int k = 1; k < ROOT_W + Q_W; k++) begin
				pos_dl_q[k] <= pos_dl_q[k-1];
			end
			nm_dl_q[0] <= '{n: n_w, m: m_w};
			for (int k = 1; k < Q_W; k++) begin
				nm_dl_q[k] <= nm_dl_q[k-1];
			end
		end
	end

	// unit vectors and inverse distances
	pos_t           pa;
	logic [Q_W-1:0] ua_w [3];
	logic [Q_W-1:0] ur_w [3];
	logic [Q_W-1:0] im_w;
	logic [Q_W-1:0] imx_w;
	assign pa = pos_dl_q[ROOT_W-1];

	for (genvar i = 0; i < 3; i++) begin : g_unit
		pfv_div u_diva (
			.clk(clk), .en(en),
			.num({16'd0, pa.dg[i], 16'd0}), .den(n_w), .quo(ua_w[i])
		);
		pfv_div u_divr (
			.clk(clk), .en(en),
			.num({16'd0, pa.ob[i], 16'd0}), .den(m_w), .quo(ur_w[i])
		);
	end

	pfv_div u_divim (
		.clk(clk), .en(en), .num(64'h1_0000_0000), .den(m_w), .quo(im_w)
	);
	pfv_div u_divimx (
		.clk(clk), .en(en), .num(64'h1_0000_0000), .den({1'b0, md_q}), .quo(imx_w)
	);

	pos_t pd;
	nm_t  nd;
	assign pd = pos_dl_q[ROOT_W+Q_W-1];
	assign nd = nm_dl_q[Q_W-1];

	// ---------------- s4: attraction, first repulsion product ----------------
	logic [2:0][MAG_W-1:0] att_s4;
	logic [2:0]            attn_s4;
	logic [2:0][Q_W-1:0]   ur_s4;
	logic [2:0]            obp_s4;
	logic [Q_W-1:0]        im_s4;
	logic [MAG_W-1:0]      q1_s4;
	logic                  ron_s4;
	logic [2:0][63:0]      conp;
	logic [2:0][63:0]      parp;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			conp[i] = 64'(ua_w[i][16:0]) * 64'(p_q);
			parp[i] = 64'(pd.dg[i]) * 64'(ag_q);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (nd.n < {1'b0, sr_q}) begin
					att_s4[i] <= '0;
				end else if (nd.n > {1'b0, pb_q}) begin
					att_s4[i] <= sat_mag(conp[i][63:16]);
				end else begin
					att_s4[i] <= sat_mag(parp[i][63:16]);
				end
				ur_s4[i] <= ur_w[i];
			end
			attn_s4 <= pd.dg_neg;
			obp_s4  <= pd.ob_pos;
			im_s4   <= im_w;
			q1_s4   <= qmul({16'd0, rg_q}, im_w - imx_w);
			ron_s4  <= pd.ov && (nd.m != '0) && (nd.m < {1'b0, md_q});
		end
	end

	// ---------------- s5 to s8: repulsion magnitude ----------------
	logic [2:0][MAG_W-1:0] att_s5, att_s6, att_s7, att_s8, att_s9;
	logic [2:0]            attn_s5, attn_s6, attn_s7, attn_s8, attn_s9;
	logic [2:0][Q_W-1:0]   ur_s5, ur_s6, ur_s7, ur_s8;
	logic [2:0]            obp_s5, obp_s6, obp_s7, obp_s8, obp_s9;
	logic [Q_W-1:0]        im_s5, im_s6;
	logic                  ron_s5, ron_s6, ron_s7, ron_s8;
	logic [PP_W-1:0]       q2l_s5, q2h_s5, mgl_s7, mgh_s7;
	logic [MAG_W-1:0]      q2_s6, mag_s8;
	logic [2:0][MAG_W-1:0] rep_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			// s5: split product of the first term by the inverse distance
			att_s5  <= att_s4;
			attn_s5 <= attn_s4;
			ur_s5   <= ur_s4;
			obp_s5  <= obp_s4;
			im_s5   <= im_s4;
			ron_s5  <= ron_s4;
			q2l_s5  <= PP_W'(q1_s4[LO_W-1:0]) * PP_W'(im_s4);
			q2h_s5  <= PP_W'(q1_s4[MAG_W-1:LO_W]) * PP_W'(im_s4);

			// s6: second term
			att_s6  <= att_s5;
			attn_s6 <= attn_s5;
			ur_s6   <= ur_s5;
			obp_s6  <= obp_s5;
			im_s6   <= im_s5;
			ron_s6  <= ron_s5;
			q2_s6   <= qjoin(q2h_s5, q2l_s5);

			// s7: split product of the second term by the inverse distance
			att_s7  <= att_s6;
			attn_s7 <= attn_s6;
			ur_s7   <= ur_s6;
			obp_s7  <= obp_s6;
			ron_s7  <= ron_s6;
			mgl_s7  <= PP_W'(q2_s6[LO_W-1:0]) * PP_W'(im_s6);
			mgh_s7  <= PP_W'(q2_s6[MAG_W-1:LO_W]) * PP_W'(im_s6);

			// s8: repulsion magnitude
			att_s8  <= att_s7;
			attn_s8 <= attn_s7;
			ur_s8   <= ur_s7;
			obp_s8  <= obp_s7;
			ron_s8  <= ron_s7;
			mag_s8  <= qjoin(mgh_s7, mgl_s7);

			// s9: repulsive components
			att_s9  <= att_s8;
			attn_s9 <= attn_s8;
			obp_s9  <= obp_s8;
			for (int i = 0; i < 3; i++) begin
				rep_s9[i] <= ron_s8 ? qmul({1'b0, mag_s8}, {16'd0, ur_s8[i][16:0]}) : '0;
			end
		end
	end

	// ---------------- s10: gradient ----------------
	logic signed [GRD_W-1:0] grad_s10 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				grad_s10[i] <=
					(attn_s9[i] ? -$signed({2'b00, att_s9[i]}) : $signed({2'b00, att_s9[i]})) +
					(obp_s9[i]  ? -$signed({2'b00, rep_s9[i]}) : $signed({2'b00, rep_s9[i]}));
			end
		end
	end

	// ---------------- s11: magnitudes ----------------
	logic [2:0][GRD_W-1:0] ga_s11;
	logic [2:0]            gn_s11;
	logic [GRD_W-1:0]      gor_w;
	logic [2:0][GRD_W-1:0] ga_w;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ga_w[i] = grad_s10[i][GRD_W-1] ? GRD_W'(-grad_s10[i]) : GRD_W'(grad_s10[i]);
		end
		gor_w = ga_w[0] | ga_w[1] | ga_w[2];
	end

	logic [GRD_W-1:0] gor_s11;
	always_ff @(posedge clk) begin
		if (en) begin
			ga_s11  <= ga_w;
			gor_s11 <= gor_w;
			for (int i = 0; i < 3; i++) begin
				gn_s11[i] <= grad_s10[i][GRD_W-1];
			end
		end
	end

	// ---------------- s12: shift amount ----------------
	logic [2:0][GRD_W-1:0] ga_s12;
	logic [2:0]            gn_s12;
	logic                  zero_s12;
	logic [SH_W-1:0]       sh_s12;
	logic [5:0]            mp_w;
	assign mp_w = msb_pos(gor_s11);

	always_ff @(posedge clk) begin
		if (en) begin
			ga_s12   <= ga_s11;
			gn_s12   <= gn_s11;
			zero_s12 <= (gor_s11 == '0);
			sh_s12   <= (mp_w >= 6'(H_W)) ? SH_W'(mp_w - 6'(H_W - 1)) : '0;
		end
	end

	// ---------------- s13: scaled gradient ----------------
	logic [2:0][H_W-1:0] h_s13;
	logic [2:0]          gn_s13;
	logic                zero_s13;
	logic [GRD_W-1:0]    hs_w [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			hs_w[i] = ga_s12[i] >> sh_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				h_s13[i] <= hs_w[i][H_W-1:0];
			end
			gn_s13   <= gn_s12;
			zero_s13 <= zero_s12;
		end
	end

	// ---------------- s14: squares and speed products ----------------
	logic [2:0][HV_W-1:0] hsq_s14;
	fin_t                 fin_s14;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				hsq_s14[i]    <= HV_W'(h_s13[i]) * HV_W'(h_s13[i]);
				fin_s14.hv[i] <= HV_W'(h_s13[i]) * HV_W'(sp_q);
			end
			fin_s14.neg  <= gn_s13;
			fin_s14.zero <= zero_s13;
		end
	end

	// ---------------- s15: gradient sum of squares ----------------
	fin_t        fin_s15;
	logic [63:0] sumh_s15;
	always_ff @(posedge clk) begin
		if (en) begin
			fin_s15  <= fin_s14;
			sumh_s15 <= 64'(hsq_s14[0]) + 64'(hsq_s14[1]) + 64'(hsq_s14[2]);
		end
	end

	logic [ROOT_W-1:0] nn_w;
	pfv_isqrt u_sqh (.clk(clk), .en(en), .rad(sumh_s15), .root(nn_w));

	fin_t fin_dl_q [ROOT_W];
	sg_t  sg_dl_q  [Q_W];
	fin_t fb;
	assign fb = fin_dl_q[ROOT_W-1];

	always_ff @(posedge clk) begin
		if (en) begin
			fin_dl_q[0] <= fin_s15;
			for (int k = 1; k < ROOT_W; k++) begin
				fin_dl_q[k] <= fin_dl_q[k-1];
			end
			sg_dl_q[0] <= '{neg: fb.neg, zero: fb.zero};
			for (int k = 1; k < Q_W; k++) begin
				sg_dl_q[k] <= sg_dl_q[k-1];
			end
		end
	end

	// speed-scaled unit vector
	logic [Q_W-1:0] v_w [3];
	for (genvar i = 0; i < 3; i++) begin : g_vel
		pfv_div u_divv (
			.clk(clk), .en(en),
			.num({{(NUM_W-HV_W){1'b0}}, fb.hv[i]}), .den(nn_w), .quo(v_w[i])
		);
	end

	// ---------------- s16: output register ----------------
	sg_t sg;
	assign sg = sg_dl_q[Q_W-1];

	logic [2:0][31:0] vel_s16;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (sg.zero) begin
					vel_s16[i] <= '0;
				end else if (sg.neg[i]) begin
					vel_s16[i] <= 32'd0 - v_w[i][31:0];
				end else begin
					vel_s16[i] <= v_w[i][31:0];
				end
			end
		end
	end

	assign m_tdata = vel_s16;

endmodule

// ----- hdl/pfv_checker.sv -----
// ----------------------------------------------------------------------------
// pfv_checker - port-level checks for potential_field_velocity
// Watches the stream handshakes and reset behavior of the top level.
// ----------------------------------------------------------------------------
module pfv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// input side moves exactly when the output is free or taken
	a_ready: assert property (@(posedge clk)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output state");

	// no result during reset
	a_reset: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("result valid during reset");

endmodule

bind potential_field_velocity pfv_checker u_chk (.*);

// ----- dv/tb_potential_field_velocity.sv -----
// ----------------------------------------------------------------------------
// tb_potential_field_velocity - self-checking bench of the velocity block
// Drives poses on the input stream, predicts each velocity command with a
// bit-exact Q16.16 model of the potential field, and compares every output
// transaction in order. A directed table runs first, then randomized poses
// under several register settings with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_potential_field_velocity
	import pfv_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam bit [63:0] GRAD_MAX = 64'h7FFF_FFFF_FFFF;
	localparam bit [63:0] LIM31    = 64'h8000_0000;
	localparam int        LATENCY  = 146;
	localparam longint    S32_MAX  = 64'sd2147483647;
	localparam longint    S32_MIN  = -64'sd2147483648;

	typedef struct {
		logic [31:0] pos [9];   // robot xyz, goal xyz, obstacle xyz
		logic        obs_ok;
	} pose_t;

	typedef struct {
		pose_t       pose;
		bit          typed;
		logic [95:0] vel;
	} row_t;

	typedef struct {
		logic [95:0] vel;
		bit          typed;
		logic [95:0] typed_vel;
	} vel_exp_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [287:0]         s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [95:0]          m_tdata;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_wdata;

	// side information that travels with the pose being offered
	bit          cur_typed;
	logic [95:0] cur_typed_vel;

	bit [63:0] k_rgain, k_again, k_maxd, k_bound, k_radius, k_speed;

	vel_exp_t vel_q [$];
	int       errors;
	bit       quiet;
	bit       hold_req;
	bit       hold_on;

	potential_field_velocity i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	// ---------------------------------------------------------------- model
	function automatic bit [63:0] mag64(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic bit [63:0] isqrt(bit [63:0] v);
		bit [63:0] r;
		bit [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic bit [63:0] vec_norm(longint a, longint b, longint c);
		return isqrt(mag64(a) * mag64(a) + mag64(b) * mag64(b) + mag64(c) * mag64(c));
	endfunction

	function automatic bit [63:0] qmul_sat(bit [63:0] a, bit [63:0] b);
		bit [63:0] p;
		if (a == 0 || b == 0)
			return 0;
		if (a > 64'hFFFF_FFFF_FFFF_FFFF / b)
			return GRAD_MAX;
		p = (a * b) >> 16;
		return p > GRAD_MAX ? GRAD_MAX : p;
	endfunction

	function automatic logic [95:0] predict_velocity(pose_t p);
		longint    dg [3];
		longint    dob [3];
		longint    att [3];
		longint    rep [3];
		longint    grad [3];
		longint    t;
		bit [63:0] n, m, pg, u, mg, im, imax, rmag, sum, nn, v;
		bit [63:0] h [3];
		int        s;
		logic [95:0] r;
		for (int i = 0; i < 3; i++) begin
			t = longint'($signed(p.pos[3+i])) - longint'($signed(p.pos[i]));
			dg[i] = t > S32_MAX ? S32_MAX : (t < S32_MIN ? S32_MIN : t);
			t = longint'($signed(p.pos[6+i])) - longint'($signed(p.pos[i]));
			dob[i] = t > S32_MAX ? S32_MAX : (t < S32_MIN ? S32_MIN : t);
			att[i] = 0;
			rep[i] = 0;
		end
		// attraction: zero, parabolic or conic
		n = vec_norm(dg[0], dg[1], dg[2]);
		if (n >= k_radius) begin
			pg = (k_bound * k_again) >> 16;
			for (int i = 0; i < 3; i++) begin
				if (n > k_bound) begin
					u = (mag64(dg[i]) << 16) / n;
					mg = (u * pg) >> 16;
				end else begin
					mg = (mag64(dg[i]) * k_again) >> 16;
				end
				if (mg > GRAD_MAX)
					mg = GRAD_MAX;
				att[i] = dg[i] < 0 ? -longint'(mg) : longint'(mg);
			end
		end
		// repulsion away from a valid, close obstacle
		if (p.obs_ok) begin
			m = vec_norm(dob[0], dob[1], dob[2]);
			if (m != 0 && m < k_maxd) begin
				im = (64'd1 << 32) / m;
				imax = (64'd1 << 32) / k_maxd;
				rmag = qmul_sat(qmul_sat(qmul_sat(k_rgain, im - imax), im), im);
				for (int i = 0; i < 3; i++) begin
					u = (mag64(dob[i]) << 16) / m;
					mg = qmul_sat(rmag, u);
					rep[i] = dob[i] > 0 ? -longint'(mg) : longint'(mg);
				end
			end
		end
		for (int i = 0; i < 3; i++)
			grad[i] = att[i] + rep[i];
		if (grad[0] == 0 && grad[1] == 0 && grad[2] == 0)
			return '0;
		// normalize and scale to the speed
		s = 0;
		while ((mag64(grad[0]) >> s) >= LIM31 || (mag64(grad[1]) >> s) >= LIM31 ||
		       (mag64(grad[2]) >> s) >= LIM31)
			s++;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			h[i] = mag64(grad[i]) >> s;
			sum += h[i] * h[i];
		end
		nn = isqrt(sum);
		for (int i = 0; i < 3; i++) begin
			v = nn != 0 ? (h[i] * k_speed) / nn : 0;
			if (grad[i] < 0)
				v = 64'd0 - v;
			r[32*i +: 32] = v[31:0];
		end
		return r;
	endfunction

	// ------------------------------------------------------------ stimulus
	function automatic pose_t mk_pose(int rx, int ry, int rz, int gx, int gy, int gz,
	                                  int ox, int oy, int oz, bit ok);
		pose_t p;
		p.pos = '{rx, ry, rz, gx, gy, gz, ox, oy, oz};
		p.obs_ok = ok;
		return p;
	endfunction

	function automatic int near_offset(int range);
		return int'($urandom_range(0, 2 * range)) - range;
	endfunction

	function automatic pose_t rand_pose();
		pose_t p;
		int    mode;
		int    range;
		mode = $urandom_range(0, 9);
		range = ($urandom_range(0, 3) == 0) ? (1 << 22) : (1 << 18);
		for (int i = 0; i < 3; i++)
			p.pos[i] = (mode == 9) ? $urandom : near_offset(1 << 20);
		for (int i = 0; i < 3; i++) begin
			case (mode)
				9: begin
					p.pos[3+i] = $urandom;
					p.pos[6+i] = $urandom;
				end
				8: begin
					p.pos[3+i] = p.pos[i];
					p.pos[6+i] = p.pos[i] + near_offset(1 << 17);
				end
				7: begin
					p.pos[3+i] = p.pos[i] + near_offset(range);
					p.pos[6+i] = p.pos[i] + near_offset(1 << 9);
				end
				default: begin
					p.pos[3+i] = p.pos[i] + near_offset(range);
					p.pos[6+i] = p.pos[i] + near_offset(1 << 18);
				end
			endcase
		end
		p.obs_ok = $urandom_range(0, 4) != 0;
		return p;
	endfunction

	task automatic send_pose(pose_t p, bit typed, logic [95:0] tv);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {p.pos[8], p.pos[7], p.pos[6], p.pos[5], p.pos[4], p.pos[3],
		            p.pos[2], p.pos[1], p.pos[0]};
		s_tuser <= p.obs_ok;
		cur_typed <= typed;
		cur_typed_vel <= tv;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (vel_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_REPULSE_GAIN:     k_rgain = val;
			REG_ATTRACT_GAIN:     k_again = val;
			REG_REPULSE_MAX_DIST: k_maxd = val[30:0];
			REG_PARABOLIC_BOUND:  k_bound = val[30:0];
			REG_SUCCESS_RADIUS:   k_radius = val[30:0];
			REG_ROBOT_SPEED:      k_speed = val[30:0];
			default: ;
		endcase
	endtask

	task automatic write_all(logic [31:0] rg, logic [31:0] ag, logic [31:0] md,
	                         logic [31:0] pb, logic [31:0] sr, logic [31:0] sp);
		write_reg(REG_REPULSE_GAIN, rg);
		write_reg(REG_ATTRACT_GAIN, ag);
		write_reg(REG_REPULSE_MAX_DIST, md);
		write_reg(REG_PARABOLIC_BOUND, pb);
		write_reg(REG_SUCCESS_RADIUS, sr);
		write_reg(REG_ROBOT_SPEED, sp);
	endtask

	task automatic run_random(int count);
		for (int k = 0; k < count; k++)
			send_pose(rand_pose(), 1'b0, '0);
	endtask

	// ------------------------------------------------------------ monitors
	// predict at each accepted input transaction
	always @(posedge clk) begin
		vel_exp_t e;
		pose_t    p;
		if (arst_n && s_tvalid && s_tready) begin
			for (int i = 0; i < 9; i++)
				p.pos[i] = s_tdata[32*i +: 32];
			p.obs_ok = s_tuser;
			e.vel = predict_velocity(p);
			e.typed = cur_typed;
			e.typed_vel = cur_typed_vel;
			vel_q.push_back(e);
		end
	end

	// check each output transaction against the oldest prediction
	always @(posedge clk) begin
		vel_exp_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (vel_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected velocity %h", m_tdata);
			end else begin
				e = vel_q.pop_front();
				for (int i = 0; i < 3; i++) begin
					if (m_tdata[32*i +: 32] !== e.vel[32*i +: 32] ||
					    (e.typed && m_tdata[32*i +: 32] !== e.typed_vel[32*i +: 32])) begin
						errors++;
						if (errors <= 10)
							$display("velocity[%0d] mismatch: expected %h (table %h) got %h",
							         i, e.vel[32*i +: 32], e.typed_vel[32*i +: 32],
							         m_tdata[32*i +: 32]);
					end
				end
			end
		end
	end

	// output-side stalls: short random bursts plus one long hold
	always @(posedge clk) begin
		int stall_left;
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (hold_on) begin
			m_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 3);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// long hold counted here so the input side keeps offering poses
	initial begin
		hold_on = 1'b0;
		wait (hold_req);
		hold_on = 1'b1;
		repeat (400) @(posedge clk);
		hold_on = 1'b0;
	end

	// ------------------------------------------------------------ sequence
	initial begin
		row_t rows [$];
		row_t rw;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		cur_typed = 1'b0;
		cur_typed_vel = '0;
		errors = 0;
		quiet = 1'b0;
		hold_req = 1'b0;
		k_rgain = 65536;
		k_again = 65536;
		k_maxd = 131072;
		k_bound = 65536;
		k_radius = 16384;
		k_speed = 32768;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, reset settings
		rw.typed = 1;
		// zero gradient: robot at goal, no obstacle
		rw.pose = mk_pose(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		rw.vel = '0;
		rows.push_back(rw);
		// obstacle exactly at the robot gives no repulsion
		rw.pose = mk_pose(5, 6, 7, 5, 6, 7, 5, 6, 7, 1);
		rows.push_back(rw);
		// inside the success radius
		rw.pose = mk_pose(0, 0, 0, 100, 0, 0, 0, 0, 0, 0);
		rows.push_back(rw);
		// parabolic along +x
		rw.pose = mk_pose(0, 0, 0, 32768, 0, 0, 0, 0, 0, 0);
		rw.vel = {32'd0, 32'd0, 32'd32768};
		rows.push_back(rw);
		// conic along -y
		rw.pose = mk_pose(0, 0, 0, 0, -196608, 0, 0, 0, 0, 0);
		rw.vel = {32'd0, -32'sd32768, 32'd0};
		rows.push_back(rw);
		// saturated difference along +x, obstacle far away
		rw.pose = mk_pose(-2147483648, 0, 0, 2147483647, 0, 0, 2147483647, 0, 0, 1);
		rw.vel = {32'd0, 32'd0, 32'd32768};
		rows.push_back(rw);
		// saturated difference along -z
		rw.pose = mk_pose(0, 0, 2147483647, 0, 0, -2147483648, 0, 0, 0, 0);
		rw.vel = {-32'sd32768, 32'd0, 32'd0};
		rows.push_back(rw);
		rw.typed = 0;
		rw.vel = '0;
		// obstacle valid and close, very close, at the bound, just inside it, very close
		rw.pose = mk_pose(0, 0, 0, 65536, 65536, 0, 16384, 0, 0, 1);
		rows.push_back(rw);
		rw.pose = mk_pose(0, 0, 0, 65536, 0, 0, 0, 1, 0, 1);
		rows.push_back(rw);
		rw.pose = mk_pose(0, 0, 0, 0, 0, 65536, 131072, 0, 0, 1);
		rows.push_back(rw);
		rw.pose = mk_pose(0, 0, 0, 0, 0, 65536, 131071, 0, 0, 1);
		rows.push_back(rw);
		rw.pose = mk_pose(0, 0, 0, 0, 0, 65536, 0, -1, 1, 1);
		rows.push_back(rw);
		// all fields at -1, then all fields at their extremes
		rw.pose = mk_pose(-1, -1, -1, -1, -1, -1, -1, -1, -1, 1);
		rows.push_back(rw);
		rw.pose = mk_pose(2147483647, -2147483648, 2147483647, -2147483648, 2147483647,
		                  -2147483648, -2147483648, 2147483647, -2147483648, 1);
		rows.push_back(rw);
		rw.pose = mk_pose(-2147483648, 2147483647, -2147483648, 2147483647, -2147483648,
		                  2147483647, 2147483647, -2147483648, 2147483647, 0);
		rows.push_back(rw);
		foreach (rows[i])
			send_pose(rows[i].pose, rows[i].typed, rows[i].vel);
		run_random(100);
		drain();

		// maximum gains, distances and speed, no success radius
		write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0,
		          32'h7FFF_FFFF);
		foreach (rows[i])
			send_pose(rows[i].pose, 1'b0, '0);
		run_random(80);
		drain();

		// zero gains, smallest distance, huge radius, zero speed
		write_all(32'h0, 32'h0, 32'h1, 32'h0, 32'h7FFF_FFFF, 32'h0);
		run_random(25);
		drain();

		// top bits dropped: distance becomes zero, bound and speed one
		write_all(32'h0002_0000, 32'h0000_8000, 32'h8000_0000, 32'h8001_0000, 32'h0,
		          32'h8001_0000);
		write_reg(3'd6, 32'h1234_5678);
		write_reg(3'd7, 32'hFFFF_FFFF);
		run_random(80);
		drain();

		// moderate random settings with the long output hold
		write_all($urandom_range(0, 32'h0008_0000), $urandom_range(0, 32'h0004_0000),
		          $urandom_range(32'h0001_0000, 32'h0008_0000),
		          $urandom_range(0, 32'h0004_0000), $urandom_range(0, 32'h0000_8000),
		          $urandom_range(1, 32'h0010_0000));
		run_random(40);
		hold_req = 1'b1;
		run_random(100);
		drain();

		// back to defaults, no idling at the end
		write_all(32'd65536, 32'd65536, 32'd131072, 32'd65536, 32'd16384, 32'd32768);
		run_random(60);
		quiet = 1'b1;
		run_random(60);
		drain();

		if (errors == 0 && vel_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// stop a run that hangs
	initial begin
		#3ms;
		$display("simulation failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/pfv_pkg.sv
hdl/pfv_isqrt.sv
hdl/pfv_div.sv
hdl/potential_field_velocity.sv
hdl/pfv_checker.sv
dv/tb_potential_field_velocity.sv
